// File: src/hcbp_pkg.sv
package hcbp_pkg;

    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int SYMBOLS_DEF      = 256;
    localparam int BYTE_W           = 8;
    localparam int SYM_W            = 8;
    localparam int CODE_IN_W        = 32;
    localparam int LEN_IN_W         = 6;
    localparam int FUNC_W           = 3;
    localparam int SKIP_W           = 3;
    localparam int PEND_W           = 7;
    localparam int PCNT_W           = 3;
    localparam int S_TDATA_W        = 48;

    typedef enum logic [FUNC_W-1:0] {
        FN_LOAD   = 3'd0,
        FN_ENCODE = 3'd1,
        FN_TAIL   = 3'd2,
        FN_FLUSH  = 3'd3,
        FN_START  = 3'd4
    } t_func;

endpackage

// File: src/hcbp_ram.sv
module hcbp_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                     i_wr_data,
    input  logic                                 i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// File: src/huffman_code_bit_packer.sv
// Huffman encoder back end: packs table codes MSB-first into bytes.
// Slave channel (s_*) carries one command word per handshake; tuser holds
// the command (load entry, encode, tail, flush, start block), tdata holds
// symbol, code and code length. Master channel (m_*) returns packed bytes,
// tlast marks the final byte caused by one input word.
// Load, start block, an empty flush and an ignored tail complete at the
// accepting edge; ready stays high.
// Encode: the table read runs in ST_LOOKUP, with the drop of leading block
// bits folded into the alignment shift; ST_PACK then moves the kept code bits
// through the shared code shifter, one output byte per step, until they are
// used up or fewer than a byte remain, which go to the pending bits.
// A tail reads the table in ST_LOOKUP and shifts in ST_PACK; a non-empty flush
// passes through ST_FLUSH.
// Ready is low while a word is in work. The output register lets a new word
// be accepted while a byte still waits; when the receiver stalls and a new
// byte is complete, the sequencer holds until the register frees.
// The user writes skip_bits via cfg_wr_en / cfg_wr_data only while idle; the
// block does not enforce this. Reset clears pending bits, counts, tail flag,
// skip_bits and output valid; the code table is undefined until loaded.
module huffman_code_bit_packer
    import hcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
    parameter int SYMBOLS      = SYMBOLS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // symbol[7:0], code_bits[39:8], code_len[45:40], zero[47:46]
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    // func[2:0]
    input  logic [FUNC_W-1:0]     i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // out_byte[7:0]
    output logic [BYTE_W-1:0]     o_m_tdata,
    output logic                  o_m_tlast,
    input  logic                  i_cfg_wr_en,
    input  logic [SKIP_W-1:0]     i_cfg_wr_data
);

    localparam int CODE_W = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
    localparam int LEN_W  = $clog2(CODE_W + 1);
    localparam int ENT_W  = CODE_W + LEN_W;
    localparam int AW     = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int SH_W   = $clog2(CODE_W + BYTE_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_PACK,
        ST_FLUSH
    } t_state;

    t_state              r_state, n_state;
    logic [CODE_W-1:0]   r_code, n_code;
    logic [LEN_W-1:0]    r_rem, n_rem;
    logic [PEND_W-1:0]   r_pend, n_pend;
    logic [PCNT_W-1:0]   r_pcnt, n_pcnt;
    logic [SKIP_W-1:0]   r_dropped, n_dropped;
    logic [SKIP_W-1:0]   r_skip, n_skip;
    logic                r_tail_done, n_tail_done;
    logic                r_is_tail, n_is_tail;
    logic                r_sym_ok, n_sym_ok;
    logic                r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]   r_out_byte, n_out_byte;
    logic                r_out_last, n_out_last;

    logic                w_accept;
    logic [SYM_W-1:0]    w_sym;
    logic [CODE_IN_W-1:0] w_code_in;
    logic [LEN_IN_W-1:0] w_len_in;
    logic                w_sym_ok;
    logic [LEN_W-1:0]    w_len_sat;
    logic [CODE_IN_W:0]  w_mask;
    logic [CODE_IN_W-1:0] w_code_masked;
    logic                w_wr_en;
    logic                w_rd_en;
    logic [ENT_W-1:0]    w_rd_data;
    logic [LEN_W-1:0]    w_len_eff;
    logic [SKIP_W-1:0]   w_need;
    logic [SKIP_W-1:0]   w_drop;
    logic [CODE_W-1:0]   w_sh_opnd;
    logic [SH_W-1:0]     w_sh_amt;
    logic [CODE_W-1:0]   w_sh_res;
    logic                w_out_free;
    logic [3:0]          w_space;
    logic [3:0]          w_k;
    logic [BYTE_W-1:0]   w_top;
    logic [BYTE_W-1:0]   w_acc;
    logic                w_full;
    logic [LEN_W-1:0]    w_rem_next;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_sym      = i_s_tdata[7:0];
    assign w_code_in  = i_s_tdata[39:8];
    assign w_len_in   = i_s_tdata[45:40];
    assign w_sym_ok   = ({1'b0, w_sym} < (SYM_W + 1)'(SYMBOLS));

    assign w_len_sat     = (w_len_in > LEN_IN_W'(CODE_W)) ? LEN_W'(CODE_W)
                                                          : w_len_in[LEN_W-1:0];
    assign w_mask        = ((CODE_IN_W + 1)'(1) << w_len_sat) - (CODE_IN_W + 1)'(1);
    assign w_code_masked = w_code_in & w_mask[CODE_IN_W-1:0];

    assign w_wr_en = w_accept && (i_s_tuser == FN_LOAD) && w_sym_ok;
    assign w_rd_en = w_accept && ((i_s_tuser == FN_ENCODE) || (i_s_tuser == FN_TAIL));

    hcbp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SYMBOLS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_sym[AW-1:0]),
        .i_wr_data ({w_code_masked[CODE_W-1:0], w_len_sat}),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_sym[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    // drop leading block bits and left-align in one shift
    assign w_len_eff = r_sym_ok ? w_rd_data[LEN_W-1:0] : '0;
    assign w_need    = (!r_is_tail && (r_skip > r_dropped)) ? (r_skip - r_dropped) : '0;
    assign w_drop    = ({{(LEN_W - SKIP_W){1'b0}}, w_need} < w_len_eff) ? w_need
                                                                         : w_len_eff[SKIP_W-1:0];

    assign w_space    = 4'd8 - {1'b0, r_pcnt};
    assign w_k        = (r_rem < LEN_W'(w_space)) ? r_rem[3:0] : w_space;
    assign w_top      = r_code[CODE_W-1 -: BYTE_W];
    assign w_acc      = ({1'b0, r_pend} << w_k) | (w_top >> (4'd8 - w_k));
    assign w_full     = (({1'b0, r_pcnt} + w_k) == 4'd8);
    assign w_rem_next = r_rem - LEN_W'(w_k);

    assign w_sh_opnd = (r_state == ST_LOOKUP) ? (r_sym_ok ? w_rd_data[ENT_W-1:LEN_W] : '0)
                                              : r_code;
    assign w_sh_amt  = (r_state == ST_LOOKUP)
                     ? (SH_W'(CODE_W) - SH_W'(w_len_eff) + SH_W'(w_drop))
                     : SH_W'(w_k);
    assign w_sh_res  = w_sh_opnd << w_sh_amt;

    assign w_out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state     = r_state;
        n_code      = r_code;
        n_rem       = r_rem;
        n_pend      = r_pend;
        n_pcnt      = r_pcnt;
        n_dropped   = r_dropped;
        n_skip      = r_skip;
        n_tail_done = r_tail_done;
        n_is_tail   = r_is_tail;
        n_sym_ok    = r_sym_ok;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;

        if (i_cfg_wr_en) begin
            n_skip = i_cfg_wr_data;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_s_tuser)
                        FN_ENCODE: begin
                            n_is_tail = 1'b0;
                            n_sym_ok  = w_sym_ok;
                            n_state   = ST_LOOKUP;
                        end
                        FN_TAIL: begin
                            if (!r_tail_done) begin
                                if (r_pcnt == '0) begin
                                    n_tail_done = 1'b1;
                                end else begin
                                    n_is_tail = 1'b1;
                                    n_sym_ok  = w_sym_ok;
                                    n_state   = ST_LOOKUP;
                                end
                            end
                        end
                        FN_FLUSH: begin
                            if (r_pcnt != '0) begin
                                n_state = ST_FLUSH;
                            end
                        end
                        FN_START: begin
                            n_pend      = '0;
                            n_pcnt      = '0;
                            n_dropped   = '0;
                            n_tail_done = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOOKUP: begin
                n_code    = w_sh_res;
                n_rem     = w_len_eff - LEN_W'(w_drop);
                n_dropped = r_dropped + w_drop;
                n_state   = ST_PACK;
            end
            ST_PACK: begin
                if (r_rem == '0) begin
                    n_state = ST_IDLE;
                end else if (!w_full) begin
                    n_pend  = w_acc[PEND_W-1:0];
                    n_pcnt  = r_pcnt + w_k[PCNT_W-1:0];
                    n_rem   = w_rem_next;
                    n_code  = w_sh_res;
                    n_state = ST_IDLE;
                end else if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = w_acc;
                    n_out_last  = r_is_tail || (w_rem_next < LEN_W'(BYTE_W));
                    n_pend      = '0;
                    n_pcnt      = '0;
                    n_rem       = w_rem_next;
                    n_code      = w_sh_res;
                    if (r_is_tail) begin
                        n_tail_done = 1'b1;
                        n_state     = ST_IDLE;
                    end else if (w_rem_next == '0) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = {1'b0, r_pend} << (4'd8 - {1'b0, r_pcnt});
                    n_out_last  = 1'b1;
                    n_pend      = '0;
                    n_pcnt      = '0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pend      <= '0;
            r_pcnt      <= '0;
            r_dropped   <= '0;
            r_skip      <= '0;
            r_tail_done <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_pcnt      <= n_pcnt;
            r_dropped   <= n_dropped;
            r_skip      <= n_skip;
            r_tail_done <= n_tail_done;
            r_out_valid <= n_out_valid;
        end
        r_code     <= n_code;
        r_rem      <= n_rem;
        r_is_tail  <= n_is_tail;
        r_sym_ok   <= n_sym_ok;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;

endmodule

// File: src/hcbp_checker.sv
module hcbp_checker
    import hcbp_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 o_s_tready,
    input logic [FUNC_W-1:0]    i_s_tuser,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [BYTE_W-1:0]    o_m_tdata,
    input logic                 o_m_tlast
);

    logic w_acc;

    assign w_acc = i_s_tvalid && o_s_tready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled output word changed");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && (i_s_tuser == FN_LOAD || i_s_tuser == FN_START) |=> o_s_tready)
        else $error("table load or block start left the block busy");

    a_encode_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_s_tuser == FN_ENCODE |=> !o_s_tready)
        else $error("encode did not start the table read");

    a_start_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_s_tuser == FN_START && !o_m_tvalid |=> !o_m_tvalid)
        else $error("block start produced a word");

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (.*);

// File: dv/testbench.sv
module testbench
    import hcbp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_CYC       = 16;
    localparam int LONG_HOLD      = 150;
    localparam int HOLD_AT        = 60;
    localparam int N_PHASES       = 5;
    localparam int RAND_PER_PHASE = 37;

    typedef struct packed {
        t_func                 f;
        logic [SYM_W-1:0]      sym;
        logic [CODE_IN_W-1:0]  code;
        logic [LEN_IN_W-1:0]   len;
        logic                  typed;
        logic [2:0]            n;
        logic [31:0]           bytes;
    } t_row;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_due;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [FUNC_W-1:0]     s_tuser = '0;
    logic                  o_m_tvalid;
    logic                  m_tready = 1'b0;
    logic [BYTE_W-1:0]     o_m_tdata;
    logic                  o_m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [SKIP_W-1:0]     cfg_wr_data = '0;

    // packer state as predicted
    logic [CODE_IN_W-1:0]  tbl_code [SYMBOLS_DEF];
    logic [LEN_IN_W-1:0]   tbl_len  [SYMBOLS_DEF];
    bit                    loaded   [SYMBOLS_DEF];
    logic [SYM_W-1:0]      live_syms [$];
    logic [PEND_W-1:0]     pend_bits = '0;
    logic [PCNT_W-1:0]     pend_cnt = '0;
    logic [SKIP_W-1:0]     drop_cnt = '0;
    logic                  tail_done = 1'b0;
    logic [SKIP_W-1:0]     skip = '0;

    logic [BYTE_W-1:0]     step_bytes [$];
    t_due                  bytes_due [$];
    int                    n_err = 0;
    int                    n_rcvd = 0;
    bit                    src_idle = 1'b1;
    bit                    snk_idle = 1'b1;

    huffman_code_bit_packer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tlast     (o_m_tlast),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void pack_bit(input logic b);
        logic [7:0] acc;
        acc = {pend_bits, b};
        if (pend_cnt == 3'd7) begin
            step_bytes.push_back(acc);
            pend_bits = '0;
            pend_cnt  = '0;
        end else begin
            pend_bits = acc[6:0];
            pend_cnt  = pend_cnt + 3'd1;
        end
    endfunction

    function automatic void predict_bytes(input t_func f, input logic [SYM_W-1:0] sym,
                                          input logic [CODE_IN_W-1:0] code,
                                          input logic [LEN_IN_W-1:0] len);
        logic [CODE_IN_W-1:0] c;
        int                   l;
        step_bytes.delete();
        c = tbl_code[sym];
        l = int'(tbl_len[sym]);
        case (f)
            FN_LOAD: begin
                l = (int'(len) > MAX_CODE_LEN_DEF) ? MAX_CODE_LEN_DEF : int'(len);
                tbl_code[sym] = code & 32'((64'd1 << l) - 64'd1);
                tbl_len[sym]  = 6'(l);
                if (!loaded[sym]) begin
                    loaded[sym] = 1'b1;
                    live_syms.push_back(sym);
                end
            end
            FN_ENCODE: begin
                for (int i = l; i > 0; i--) begin
                    if (drop_cnt < skip) drop_cnt = drop_cnt + 3'd1;
                    else pack_bit(c[i-1]);
                end
            end
            FN_TAIL: begin
                if (!tail_done) begin
                    if (pend_cnt == 3'd0) begin
                        tail_done = 1'b1;
                    end else begin
                        for (int i = l; i > 0; i--) begin
                            pack_bit(c[i-1]);
                            if (step_bytes.size() > 0) begin
                                tail_done = 1'b1;
                                break;
                            end
                        end
                    end
                end
            end
            FN_FLUSH: begin
                if (pend_cnt != 3'd0) begin
                    step_bytes.push_back(8'(int'(pend_bits) << (8 - int'(pend_cnt))));
                    pend_bits = '0;
                    pend_cnt  = '0;
                end
            end
            FN_START: begin
                pend_bits = '0;
                pend_cnt  = '0;
                drop_cnt  = '0;
                tail_done = 1'b0;
            end
            default: ;
        endcase
    endfunction

    function automatic t_row drow(input t_func f, input logic [7:0] sym,
                                  input logic [31:0] code, input logic [5:0] len,
                                  input logic typed, input logic [2:0] n,
                                  input logic [31:0] bytes);
        t_row r;
        r.f     = f;
        r.sym   = sym;
        r.code  = code;
        r.len   = len;
        r.typed = typed;
        r.n     = n;
        r.bytes = bytes;
        return r;
    endfunction

    function automatic t_row rand_row();
        t_row r;
        int   pick;
        r      = '0;
        pick   = $urandom_range(0, 99);
        r.sym  = live_syms[$urandom_range(0, live_syms.size() - 1)];
        r.code = $urandom();
        r.len  = 6'($urandom_range(0, 32));
        if (pick < 12) begin
            r.f   = FN_LOAD;
            r.sym = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 4))
                0: r.len = 6'd32;
                1: r.len = 6'($urandom_range(0, 8));
                default: r.len = 6'($urandom_range(1, 20));
            endcase
        end else if (pick < 70) begin
            r.f = FN_ENCODE;
        end else if (pick < 80) begin
            r.f = FN_TAIL;
        end else if (pick < 92) begin
            r.f = FN_FLUSH;
        end else begin
            r.f = FN_START;
        end
        return r;
    endfunction

    task automatic send_word(input t_row r);
        int gap;
        gap = src_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.f;
        s_tdata  <= {2'b00, r.len, r.code, r.sym};
        do @(negedge i_clk); while (!o_s_tready);
        @(posedge i_clk);
        predict_bytes(r.f, r.sym, r.code, r.len);
        if (r.typed) begin
            for (int k = 0; k < int'(r.n); k++)
                bytes_due.push_back(t_due'{r.bytes[8*k +: 8], k == int'(r.n) - 1});
        end else begin
            foreach (step_bytes[k])
                bytes_due.push_back(t_due'{step_bytes[k], k == step_bytes.size() - 1});
        end
    endtask

    // hold the sender until the block has drained
    task automatic settle();
        s_tvalid <= 1'b0;
        while (bytes_due.size() != 0) @(posedge i_clk);
        repeat (IDLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_skip(input logic [SKIP_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        skip = v;
    endtask

    initial begin : rx
        int          gap;
        logic [7:0]  got_b;
        logic        got_l;
        t_due        want;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (n_rcvd == HOLD_AT) gap = LONG_HOLD;
            else gap = snk_idle ? $urandom_range(0, 9) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(negedge i_clk); while (!o_m_tvalid);
            got_b = o_m_tdata;
            got_l = o_m_tlast;
            @(posedge i_clk);
            n_rcvd++;
            if (bytes_due.size() == 0) begin
                n_err++;
                $display("%0t: unexpected word, expected none, got byte %02h last %0b",
                         $time, got_b, got_l);
            end else begin
                want = bytes_due.pop_front();
                if (want.data !== got_b) begin
                    n_err++;
                    $display("%0t: byte mismatch, expected %02h, got %02h",
                             $time, want.data, got_b);
                end
                if (want.last !== got_l) begin
                    n_err++;
                    $display("%0t: last mismatch, expected %0b, got %0b",
                             $time, want.last, got_l);
                end
            end
        end
    end

    initial begin : stim
        t_row        dir [$];
        logic [2:0]  skips [N_PHASES];
        skips = '{3'd7, 3'd0, 3'd3, 3'd5, 3'd0};
        skips[4] = 3'($urandom_range(1, 6));
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_skip(3'd0);

        dir.push_back(drow(FN_LOAD,   8'h00, 32'hFFFF_FFFF, 6'd32, 1'b1, 3'd0, 32'h0));
        dir.push_back(drow(FN_LOAD,   8'hFF, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0));
        dir.push_back(drow(FN_LOAD,   8'h41, 32'hFFFF_FFFF, 6'd3,  1'b1, 3'd0, 32'h0));
        dir.push_back(drow(FN_LOAD,   8'h80, 32'hA5A5_A5A5, 6'd8,  1'b1, 3'd0, 32'h0));
        dir.push_back(drow(FN_LOAD,   8'h01, 32'h5AC3_96E1, 6'd31, 1'b1, 3'd0, 32'h0));
        dir.push_back(drow(FN_LOAD,   8'h7E, 32'h0000_0001, 6'd1,  1'b1, 3'd0, 32'h0));
        dir.push_back(drow(FN_FLUSH,  8'h00, 32'h0,         6'd0,  1'b1, 3'd0, 32'h0));
        dir.push_back(drow(FN_ENCODE, 8'h00, 32'h0,         6'd0,  1'b1, 3'd4, 32'hFFFF_FFFF));
        dir.push_back(drow(FN_ENCODE, 8'h80, 32'h0,         6'd0,  1'b1, 3'd1, 32'h0000_00A5));
        dir.push_back(drow(FN_ENCODE, 8'hFF, 32'h0,         6'd0,  1'b1, 3'd0, 32'h0));
        dir.push_back(drow(FN_ENCODE, 8'h41, 32'h0,         6'd0,  1'b1, 3'd0, 32'h0));
        dir.push_back(drow(FN_FLUSH,  8'h41, 32'h0,         6'd0,  1'b1, 3'd1, 32'h0000_00E0));
        dir.push_back(drow(FN_FLUSH,  8'h41, 32'h0,         6'd0,  1'b1, 3'd0, 32'h0));
        dir.push_back(drow(FN_ENCODE, 8'h41, 32'h0,         6'd0,  1'b1, 3'd0, 32'h0));
        dir.push_back(drow(FN_TAIL,   8'h00, 32'h0,         6'd0,  1'b1, 3'd1, 32'h0000_00FF));
        dir.push_back(drow(FN_TAIL,   8'h80, 32'h0,         6'd0,  1'b1, 3'd0, 32'h0));
        dir.push_back(drow(FN_ENCODE, 8'h01, 32'h0,         6'd0,  1'b0, 3'd0, 32'h0));
        dir.push_back(drow(FN_TAIL,   8'h7E, 32'h0,         6'd0,  1'b0, 3'd0, 32'h0));
        dir.push_back(drow(FN_START,  8'h41, 32'h0,         6'd0,  1'b1, 3'd0, 32'h0));
        dir.push_back(drow(FN_TAIL,   8'h41, 32'h0,         6'd0,  1'b1, 3'd0, 32'h0));
        dir.push_back(drow(FN_ENCODE, 8'h7E, 32'h0,         6'd0,  1'b1, 3'd0, 32'h0));
        dir.push_back(drow(FN_START,  8'h7E, 32'h0,         6'd0,  1'b1, 3'd0, 32'h0));
        dir.push_back(drow(FN_ENCODE, 8'h41, 32'h0,         6'd0,  1'b1, 3'd0, 32'h0));
        dir.push_back(drow(FN_TAIL,   8'hFF, 32'h0,         6'd0,  1'b1, 3'd0, 32'h0));
        dir.push_back(drow(FN_TAIL,   8'h01, 32'h0,         6'd0,  1'b0, 3'd0, 32'h0));

        foreach (dir[k]) send_word(dir[k]);

        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            write_skip(skips[p]);
            src_idle = (p != 1 && p != 3);
            snk_idle = (p != 2 && p != 3);
            repeat (RAND_PER_PHASE) send_word(rand_row());
        end

        settle();
        if (n_err == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: huffman_code_bit_packer.f
src/hcbp_pkg.sv
src/hcbp_ram.sv
src/huffman_code_bit_packer.sv
src/hcbp_checker.sv
dv/testbench.sv
